// ===== sv/rtttl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtttl_pkg;

	// Shared restoring divider: 18-bit dividend, 10-bit divisor, one quotient bit per cycle.
	localparam int DIVIDEND_W = 18;
	localparam int DIVISOR_W  = 10;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam int CHAR_W     = 8;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 32;
	localparam int PITCH_W    = 6;
	localparam int DUR_W      = 19;

	// Octave offset applied to every note before the semitone index is formed.
	localparam int unsigned OCTAVE_SHIFT = 0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // a character transfer takes place this cycle
		logic step;      // one divider iteration
		logic whole_wr;  // store the quotient as the whole-note time
		logic out_load;  // load the note into the output register
	} ctrl_cmd_t;

	// Status from the datapath, valid together with the offered character.
	typedef struct packed {
		logic need_div;  // this character needs a division
		logic is_emit;   // the division produces a note
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/rtttl_melody_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A note end is divided in the divide state, then loaded into the output register from
// the done state. Plain characters are taken back to back; a note end, or the ':' that
// closes the header, holds the input off while the shared 18-step divider runs.
// A finished note waits in the output register; the next note end stalls until it is taken.
// Reset (arst_n low, asynchronous) returns the parser to the name phase with divisor 4,
// octave 6, tempo 63, whole-note time 0, and empties the output register.
module rtttl_melody_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Character stream in.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire logic        s_axis_tlast,   // end_of_song
	// Note stream out.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [5:0] pitch_index, [24:6] duration_ms, rest zero
	output logic             m_axis_tuser,   // pitch_error
	output logic             m_axis_tlast    // song_done
);
	import rtttl_pkg::*;

	// The controller sequences each transfer: most characters only update the
	// parser registers, while a note end or the header end runs the divider.
	ctrl_cmd_t  cmd;
	dp_status_t st;

	rtttl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	// The datapath holds the parser state, the divider that forms the whole-note
	// time (60000 / tempo, times four) and each note length (whole / divisor),
	// and the output register.
	rtttl_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.cmd          (cmd),
		.st           (st),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/rtttl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtttl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	input  wire rtttl_pkg::dp_status_t st,
	output rtttl_pkg::ctrl_cmd_t      cmd
);
	import rtttl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             emit_q;
	logic             out_valid_q;
	logic             out_free;
	logic             cnt_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cnt_last      = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.accept   = s_axis_tvalid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && st.need_div) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!emit_q) begin
					cmd.whole_wr = 1'b1;
					state_d      = ST_IDLE;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept && st.need_div) begin
				cnt_q  <= '0;
				emit_q <= st.is_emit;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_axis_tready))
		else $error("note loaded over an output that was not taken");

	a_busy_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && st.need_div) |=> !s_axis_tready)
		else $error("input stayed ready while a division was started");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |-> ##DIV_STEPS (state_q == ST_DONE))
		else $error("division did not finish after the expected number of steps");

	a_whole_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !emit_q) |=> (state_q == ST_IDLE))
		else $error("whole-note update did not return to idle");

endmodule

`default_nettype wire

// ===== sv/rtttl_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtttl_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [rtttl_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic                        s_axis_tlast,
	input  wire rtttl_pkg::ctrl_cmd_t        cmd,
	output rtttl_pkg::dp_status_t            st,
	output logic [rtttl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);
	import rtttl_pkg::*;

	localparam logic [3:0] PH_NAME   = 4'd0;
	localparam logic [3:0] PH_HDR    = 4'd1;
	localparam logic [3:0] PH_HDR_D  = 4'd2;
	localparam logic [3:0] PH_HDR_O  = 4'd3;
	localparam logic [3:0] PH_HDR_B  = 4'd4;
	localparam logic [3:0] PH_DUR    = 4'd5;
	localparam logic [3:0] PH_LETTER = 4'd6;
	localparam logic [3:0] PH_SHARP  = 4'd7;
	localparam logic [3:0] PH_DOT    = 4'd8;
	localparam logic [3:0] PH_OCT    = 4'd9;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_P     = 8'h70;

	localparam logic [9:0]  NUM_MAX     = 10'd999;
	localparam logic [9:0]  TEMPO_DFLT  = 10'd63;
	localparam logic [9:0]  DIV_DFLT    = 10'd4;
	localparam logic [2:0]  OCT_DFLT    = 3'd6;
	localparam logic [DIVIDEND_W-1:0] MS_PER_MIN = DIVIDEND_W'(60000);

	// Semitone value of a note letter, indexed by the low three bits of 'a'..'g'.
	function automatic logic [3:0] letter_val(input logic [2:0] code);
		logic [3:0] v;
		case (code)
			3'd1:    v = 4'd10;
			3'd2:    v = 4'd12;
			3'd3:    v = 4'd1;
			3'd4:    v = 4'd3;
			3'd5:    v = 4'd5;
			3'd6:    v = 4'd6;
			3'd7:    v = 4'd8;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	// Parser state.
	logic [3:0]  phase_q;
	logic [9:0]  def_div_q;
	logic [2:0]  def_oct_q;
	logic [9:0]  tempo_q;
	logic [17:0] whole_q;
	logic [9:0]  acc_q;
	logic [3:0]  letter_q;
	logic        dot_q;
	logic [3:0]  oct_q;

	// Next values.
	logic [3:0]  n_phase;
	logic [9:0]  n_def_div;
	logic [2:0]  n_def_oct;
	logic [9:0]  n_tempo;
	logic [9:0]  n_acc;
	logic [3:0]  n_letter;
	logic        n_dot;
	logic [3:0]  n_oct;
	logic        need_emit;
	logic        need_whole;
	logic        use_cur;

	// Note snapshot and divider.
	logic [PITCH_W-1:0]    snap_idx_q;
	logic                  snap_err_q;
	logic                  snap_dot_q;
	logic                  snap_done_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dvs_q;

	logic [7:0]  c;
	logic        eos;
	logic        is_digit;
	logic        is_letter;
	logic [13:0] acc_sum;
	logic [9:0]  acc_dig;
	logic        note_ph;
	logic        hdr_ph;

	logic [9:0]  s_acc;
	logic [3:0]  s_letter;
	logic        s_dot;
	logic [3:0]  s_oct;
	logic [9:0]  s_div;
	logic [4:0]  oct_eff;
	logic [7:0]  semi;
	logic        in_range;
	logic [PITCH_W-1:0] s_idx;
	logic        s_err;

	logic [DIVISOR_W:0]   trial;
	logic                 trial_ok;
	logic [DUR_W-1:0]     dur;

	assign c        = s_axis_tdata[CHAR_W-1:0];
	assign eos      = s_axis_tlast;
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign is_letter = (c >= CH_A) && (c <= CH_G);
	assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, c[3:0]};
	assign acc_dig  = (acc_sum > {4'd0, NUM_MAX}) ? NUM_MAX : acc_sum[9:0];
	assign note_ph  = (phase_q >= PH_DUR) && (phase_q <= PH_OCT);
	assign hdr_ph   = (phase_q >= PH_HDR) && (phase_q <= PH_HDR_B);

	always_comb begin
		n_phase    = phase_q;
		n_def_div  = def_div_q;
		n_def_oct  = def_oct_q;
		n_tempo    = tempo_q;
		n_acc      = acc_q;
		n_letter   = letter_q;
		n_dot      = dot_q;
		n_oct      = oct_q;
		need_emit  = 1'b0;
		need_whole = 1'b0;
		use_cur    = 1'b0;
		if (note_ph) begin
			if (c == CH_COMMA) begin
				// The comma closes the pending note with the values seen so far.
				need_emit = 1'b1;
				use_cur   = 1'b1;
				if (eos) begin
					n_phase = PH_NAME;
				end else begin
					n_phase  = PH_DUR;
					n_acc    = '0;
					n_letter = '0;
					n_dot    = 1'b0;
					n_oct    = {1'b0, def_oct_q};
				end
			end else begin
				if (phase_q == PH_DUR) begin
					if (is_digit) begin
						n_acc = acc_dig;
					end else if (is_letter) begin
						n_letter = letter_val(c[2:0]);
						n_phase  = PH_LETTER;
					end else if (c == CH_P) begin
						n_letter = '0;
						n_phase  = PH_LETTER;
					end
				end else if (c == CH_HASH && phase_q == PH_LETTER) begin
					if (letter_q != '0) begin
						n_letter = letter_q + 4'd1;
					end
					n_phase = PH_SHARP;
				end else if (c == CH_DOT) begin
					n_dot = 1'b1;
					if (phase_q < PH_DOT) begin
						n_phase = PH_DOT;
					end
				end else if (is_digit && phase_q < PH_OCT) begin
					n_oct   = c[3:0];
					n_phase = PH_OCT;
				end
				if (eos) begin
					need_emit = 1'b1;
					n_phase   = PH_NAME;
				end
			end
		end else if (hdr_ph) begin
			if (c == CH_COMMA || c == CH_COLON) begin
				if (phase_q == PH_HDR_D && acc_q != '0) begin
					n_def_div = acc_q;
				end
				if (phase_q == PH_HDR_O && acc_q >= 10'd3 && acc_q <= 10'd7) begin
					n_def_oct = acc_q[2:0];
				end
				if (phase_q == PH_HDR_B && acc_q != '0) begin
					n_tempo = acc_q;
				end
				n_phase = PH_HDR;
				if (c == CH_COLON) begin
					need_whole = 1'b1;
					n_phase    = PH_DUR;
					n_acc      = '0;
					n_letter   = '0;
					n_dot      = 1'b0;
					n_oct      = {1'b0, n_def_oct};
				end
			end else if (phase_q == PH_HDR) begin
				if (c == CH_D) begin
					n_phase = PH_HDR_D;
				end else if (c == CH_O) begin
					n_phase = PH_HDR_O;
				end else if (c == CH_B) begin
					n_phase = PH_HDR_B;
				end
				n_acc = '0;
			end else if (is_digit) begin
				n_acc = acc_dig;
			end
			if (eos) begin
				n_phase = PH_NAME;
			end
		end else begin
			n_phase = PH_NAME;
			if (c == CH_COLON) begin
				n_def_div = DIV_DFLT;
				n_def_oct = OCT_DFLT;
				n_tempo   = TEMPO_DFLT;
				n_acc     = '0;
				n_phase   = PH_HDR;
			end
			if (eos) begin
				n_phase = PH_NAME;
			end
		end
	end

	assign st.need_div = need_emit || need_whole;
	assign st.is_emit  = need_emit;

	// Operands of the note that is emitted.
	assign s_acc    = use_cur ? acc_q : n_acc;
	assign s_letter = use_cur ? letter_q : n_letter;
	assign s_dot    = use_cur ? dot_q : n_dot;
	assign s_oct    = use_cur ? oct_q : n_oct;
	assign s_div    = (s_acc != '0) ? s_acc : ((def_div_q != '0) ? def_div_q : 10'd1);
	assign oct_eff  = {1'b0, s_oct} + 5'(OCTAVE_SHIFT);
	assign semi     = {oct_eff, 3'b000} + {1'b0, oct_eff, 2'b00} + {4'd0, s_letter};
	// Index (octave - 4) * 12 + letter must land in 1..48.
	assign in_range = (semi >= 8'd49) && (semi <= 8'd96);
	assign s_idx    = (s_letter != '0 && in_range) ? PITCH_W'(semi - 8'd48) : '0;
	assign s_err    = (s_letter != '0) && !in_range;

	assign trial    = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign trial_ok = (trial >= {1'b0, dvs_q});
	assign dur      = {1'b0, quo_q} + (snap_dot_q ? {2'b00, quo_q[DIVIDEND_W-1:1]} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_NAME;
			def_div_q <= DIV_DFLT;
			def_oct_q <= OCT_DFLT;
			tempo_q   <= TEMPO_DFLT;
			whole_q   <= '0;
			acc_q     <= '0;
			letter_q  <= '0;
			dot_q     <= 1'b0;
			oct_q     <= '0;
		end else begin
			if (cmd.accept) begin
				phase_q   <= n_phase;
				def_div_q <= n_def_div;
				def_oct_q <= n_def_oct;
				tempo_q   <= n_tempo;
				acc_q     <= n_acc;
				letter_q  <= n_letter;
				dot_q     <= n_dot;
				oct_q     <= n_oct;
			end
			if (cmd.whole_wr) begin
				whole_q <= {quo_q[DIVIDEND_W-3:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (need_emit || need_whole)) begin
			rem_q       <= '0;
			quo_q       <= need_whole ? MS_PER_MIN : whole_q;
			dvs_q       <= need_whole ? ((n_tempo != '0) ? n_tempo : TEMPO_DFLT) : s_div;
			snap_idx_q  <= s_idx;
			snap_err_q  <= s_err;
			snap_dot_q  <= s_dot;
			snap_done_q <= eos;
		end else if (cmd.step) begin
			rem_q <= trial_ok ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DIVIDEND_W-2:0], trial_ok};
		end
		if (cmd.out_load) begin
			m_axis_tdata <= {(OUT_DATA_W - DUR_W - PITCH_W)'(0), dur, snap_idx_q};
			m_axis_tuser <= snap_err_q;
			m_axis_tlast <= snap_done_q;
		end
	end

endmodule

`default_nettype wire
